### hw/rtl/tsld_pkg.sv
// Shared types and constants for the tracker status LED driver.
// Self-contained; used by tsld_dir, tsld_breath and the top level.
package tsld_pkg;

   localparam int DUTY_BITS_DEF = 8;
   localparam int DUTY_OUT_W    = 8;
   localparam int ERR_W         = 13;
   localparam int DEADBAND_W    = 12;
   localparam int INTERVAL_W    = 16;
   localparam int PAUSE_W       = 16;
   localparam int TALLY_W       = 4;
   localparam int PERIOD_W      = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 12'd100;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd120;
   localparam logic [PAUSE_W-1:0]    PAUSE_RST    = 16'd1000;
   localparam logic [TALLY_W-1:0]    PULSES_RST   = 4'd2;
   localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 8'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADBAND   = 3'd0,
      CSR_INTERVAL   = 3'd1,
      CSR_PAUSE      = 3'd2,
      CSR_PULSES     = 3'd3,
      CSR_PERIOD     = 3'd4
   } csr_index_type;

   // breathing / blink settings handed to the duty unit
   typedef struct packed {
      logic [INTERVAL_W-1:0] blink_interval;
      logic [PAUSE_W-1:0]    pause_length;
      logic [TALLY_W-1:0]    pulses_per_group;
      logic [PERIOD_W-1:0]   step_period;
   } duty_cfg_type;

   typedef struct packed {
      logic left;
      logic right;
      logic up;
      logic down;
   } led_type;

endpackage

### hw/rtl/tsld_dir.sv
// Direction LED rule: dark, auto-track deadband compare, or motor flags.
// Depends on tsld_pkg.
module tsld_dir (
   input  logic                                is_dark,
   input  logic                                track_mode,
   input  logic signed [tsld_pkg::ERR_W-1:0]   horiz_error,
   input  logic signed [tsld_pkg::ERR_W-1:0]   vert_error,
   input  tsld_pkg::led_type                   moving,
   input  logic [tsld_pkg::DEADBAND_W-1:0]     deadband,
   output tsld_pkg::led_type                   leds
);

   localparam int CMP_W = tsld_pkg::ERR_W + 1;

   logic signed [CMP_W-1:0] db_pos;
   logic signed [CMP_W-1:0] db_neg;
   logic signed [CMP_W-1:0] he_x;
   logic signed [CMP_W-1:0] ve_x;

   assign db_pos = signed'({{(CMP_W-tsld_pkg::DEADBAND_W){1'b0}}, deadband});
   assign db_neg = -db_pos;
   assign he_x   = CMP_W'(horiz_error);
   assign ve_x   = CMP_W'(vert_error);

   always_comb begin
      leds = '0;
      if (is_dark) begin
         leds = '0;
      end else if (track_mode) begin
         leds.left  = he_x > db_pos;
         leds.right = he_x < db_neg;
         leds.up    = ve_x > db_pos;
         leds.down  = ve_x < db_neg;
      end else begin
         leds = moving;
      end
   end

endmodule

### hw/rtl/tsld_breath.sv
// Status duty unit: fault blink, triangle breathing ramp, rest between groups.
// Holds all duty state; depends on tsld_pkg.
module tsld_breath #(
   parameter int DUTY_BITS = tsld_pkg::DUTY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick,
   input  logic                               fault,
   input  tsld_pkg::duty_cfg_type             cfg,
   output logic [tsld_pkg::DUTY_OUT_W-1:0]    duty_next
);

   localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;

   logic [DUTY_BITS-1:0]            level_ff, level_in;
   logic                            ramp_up_ff, ramp_up_in;
   logic [tsld_pkg::TALLY_W-1:0]    tally_ff, tally_in;
   logic                            resting_ff, resting_in;
   logic [tsld_pkg::PAUSE_W-1:0]    rest_ff, rest_in;
   logic [tsld_pkg::PERIOD_W-1:0]   step_ff, step_in;
   logic [tsld_pkg::INTERVAL_W-1:0] blink_ff, blink_in;
   logic                            lit_ff, lit_in;
   logic [DUTY_BITS-1:0]            held_ff, held_in;

   logic [tsld_pkg::PAUSE_W-1:0]    rest_sat;
   logic [tsld_pkg::PERIOD_W-1:0]   step_sat;
   logic [tsld_pkg::INTERVAL_W-1:0] blink_sat;
   logic [DUTY_BITS:0]              level_inc;
   logic [DUTY_BITS-1:0]            level_dec;
   logic [tsld_pkg::TALLY_W-1:0]    tally_inc;
   logic                            go;

   assign rest_sat  = (&rest_ff)  ? rest_ff  : rest_ff + 1'b1;
   assign step_sat  = (&step_ff)  ? step_ff  : step_ff + 1'b1;
   assign blink_sat = (&blink_ff) ? blink_ff : blink_ff + 1'b1;
   assign level_inc = {1'b0, level_ff} + 1'b1;
   assign level_dec = (level_ff != '0) ? level_ff - 1'b1 : '0;
   assign tally_inc = tally_ff + 1'b1;

   always_comb begin
      level_in   = level_ff;
      ramp_up_in = ramp_up_ff;
      tally_in   = tally_ff;
      resting_in = resting_ff;
      rest_in    = rest_sat;
      step_in    = step_sat;
      blink_in   = blink_sat;
      lit_in     = lit_ff;
      held_in    = held_ff;
      go         = 1'b0;
      if (fault) begin
         // breathing frozen; toggle once the interval has run out
         if (blink_sat >= cfg.blink_interval) begin
            blink_in = '0;
            lit_in   = !lit_ff;
            held_in  = !lit_ff ? DUTY_FULL : '0;
         end
      end else begin
         go = 1'b1;
         if (resting_ff) begin
            if (rest_sat >= cfg.pause_length) begin
               resting_in = 1'b0;
            end else begin
               go = 1'b0;
            end
         end
         if (go && (step_sat >= cfg.step_period)) begin
            step_in = '0;
            if (ramp_up_ff) begin
               if (level_inc >= {1'b0, DUTY_FULL}) begin
                  level_in   = DUTY_FULL;
                  ramp_up_in = 1'b0;
               end else begin
                  level_in = level_inc[DUTY_BITS-1:0];
               end
            end else begin
               level_in = level_dec;
               if (level_dec == '0) begin
                  // falling ramp reached zero: count the pulse
                  ramp_up_in = 1'b1;
                  tally_in   = tally_inc;
                  if (tally_inc >= cfg.pulses_per_group) begin
                     tally_in   = '0;
                     resting_in = 1'b1;
                     rest_in    = '0;
                  end
               end
            end
            held_in = level_in;
         end
      end
   end

   assign duty_next = tsld_pkg::DUTY_OUT_W'(held_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         ramp_up_ff <= 1'b1;
         tally_ff   <= '0;
         resting_ff <= 1'b0;
         rest_ff    <= '0;
         step_ff    <= '1;
         blink_ff   <= '1;
         lit_ff     <= 1'b0;
         held_ff    <= '0;
      end else if (tick) begin
         level_ff   <= level_in;
         ramp_up_ff <= ramp_up_in;
         tally_ff   <= tally_in;
         resting_ff <= resting_in;
         rest_ff    <= rest_in;
         step_ff    <= step_in;
         blink_ff   <= blink_in;
         lit_ff     <= lit_in;
         held_ff    <= held_in;
      end
   end

endmodule

### hw/rtl/tracker_status_led_driver.sv
// Channel  | ports                         | direction | beat
// ---------+-------------------------------+-----------+------------------------------
// req      | req_valid/req_stall, req_*    | in        | one millisecond tick
// rsp      | rsp_valid/rsp_stall, rsp_*    | out       | LED states and status duty
// csr      | csr_we, csr_index, csr_wdata  | in        | one register write
//
// One tick per cycle while the output is not stalled: a beat is registered on entry,
// the LED and duty update runs as combinational logic, and the result lands in the
// output register. rsp_valid rises once the beat has passed the entry and output registers.
// Synchronous active-high reset clears both stages and all duty state.
// A stalled output holds its beat while the input stage still takes one more.
// Top level of the tracker status LED driver; depends on tsld_pkg, tsld_dir, tsld_breath.
module tracker_status_led_driver #(
   parameter int DUTY_BITS = tsld_pkg::DUTY_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_is_dark,
   input  logic                                    req_track_mode,
   input  logic signed [tsld_pkg::ERR_W-1:0]       req_horiz_error,
   input  logic signed [tsld_pkg::ERR_W-1:0]       req_vert_error,
   input  logic                                    req_moving_left,
   input  logic                                    req_moving_right,
   input  logic                                    req_moving_up,
   input  logic                                    req_moving_down,
   input  logic                                    req_fault,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_left_on,
   output logic                                    rsp_right_on,
   output logic                                    rsp_up_on,
   output logic                                    rsp_down_on,
   output logic [tsld_pkg::DUTY_OUT_W-1:0]         rsp_status_duty,
   input  logic                                    csr_we,
   input  logic [tsld_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tsld_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   logic [tsld_pkg::DEADBAND_W-1:0] deadband_ff;
   tsld_pkg::duty_cfg_type          cfg_ff;

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_dark_ff;
   logic                            s1_auto_ff;
   logic signed [tsld_pkg::ERR_W-1:0] s1_horiz_ff;
   logic signed [tsld_pkg::ERR_W-1:0] s1_vert_ff;
   tsld_pkg::led_type               s1_moving_ff;
   logic                            s1_fault_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   tsld_pkg::led_type               rsp_leds_ff, leds_in;
   logic [tsld_pkg::DUTY_OUT_W-1:0] rsp_duty_ff, duty_in;

   logic                            advance;
   logic                            req_take;
   logic                            tick;

   // output stage frees up when empty or being taken
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign tick        = s1_valid_ff && advance;
   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= tsld_pkg::DEADBAND_RST;
         cfg_ff.blink_interval   <= tsld_pkg::INTERVAL_RST;
         cfg_ff.pause_length     <= tsld_pkg::PAUSE_RST;
         cfg_ff.pulses_per_group <= tsld_pkg::PULSES_RST;
         cfg_ff.step_period      <= tsld_pkg::PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            tsld_pkg::CSR_DEADBAND: begin
               deadband_ff <= csr_wdata[tsld_pkg::DEADBAND_W-1:0];
            end
            tsld_pkg::CSR_INTERVAL: begin
               cfg_ff.blink_interval <= csr_wdata[tsld_pkg::INTERVAL_W-1:0];
            end
            tsld_pkg::CSR_PAUSE: begin
               cfg_ff.pause_length <= csr_wdata[tsld_pkg::PAUSE_W-1:0];
            end
            tsld_pkg::CSR_PULSES: begin
               cfg_ff.pulses_per_group <= csr_wdata[tsld_pkg::TALLY_W-1:0];
            end
            tsld_pkg::CSR_PERIOD: begin
               cfg_ff.step_period <= csr_wdata[tsld_pkg::PERIOD_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_dark_ff         <= req_is_dark;
         s1_auto_ff         <= req_track_mode;
         s1_horiz_ff        <= req_horiz_error;
         s1_vert_ff         <= req_vert_error;
         s1_moving_ff.left  <= req_moving_left;
         s1_moving_ff.right <= req_moving_right;
         s1_moving_ff.up    <= req_moving_up;
         s1_moving_ff.down  <= req_moving_down;
         s1_fault_ff        <= req_fault;
      end
      if (tick) begin
         rsp_leds_ff <= leds_in;
         rsp_duty_ff <= duty_in;
      end
   end

   tsld_dir u_dir (
      .is_dark     (s1_dark_ff),
      .track_mode  (s1_auto_ff),
      .horiz_error (s1_horiz_ff),
      .vert_error  (s1_vert_ff),
      .moving      (s1_moving_ff),
      .deadband    (deadband_ff),
      .leds        (leds_in)
   );

   tsld_breath #(
      .DUTY_BITS (DUTY_BITS)
   ) u_breath (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .fault     (s1_fault_ff),
      .cfg       (cfg_ff),
      .duty_next (duty_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_on     = rsp_leds_ff.left;
   assign rsp_right_on    = rsp_leds_ff.right;
   assign rsp_up_on       = rsp_leds_ff.up;
   assign rsp_down_on     = rsp_leds_ff.down;
   assign rsp_status_duty = rsp_duty_ff;

`ifndef SYNTH
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty entry stage");

   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      tick |=> rsp_valid)
      else $error("tick advanced but no result presented");

   a_dark_all_off: assert property (@(posedge clock) disable iff (reset)
      (tick && s1_dark_ff) |=>
         (!rsp_left_on && !rsp_right_on && !rsp_up_on && !rsp_down_on))
      else $error("direction LED lit in darkness");

   a_auto_exclusive: assert property (@(posedge clock) disable iff (reset)
      (tick && s1_auto_ff) |=> !(rsp_left_on && rsp_right_on))
      else $error("left and right both lit in auto-track");
`endif

endmodule
